// ----- rtl/core/abfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abfr_pkg
// Shared types, codes and helpers for the alpha blended rectangle fill block.
// ----------------------------------------------------------------------------
package abfr_pkg;

    // Frame store default depth in pixels
    localparam int FB_DEPTH_DEFAULT = 65536;

    // Full linear address width: x + (y + row) * pitch stays below 2**27
    localparam int FULL_AW = 27;

    // Field widths
    localparam int OP_W     = 2;
    localparam int COORD_W  = 12;
    localparam int PITCH_W  = 13;
    localparam int PIXEL_W  = 32;
    localparam int ALPHA_W  = 8;
    localparam int PROD_W   = COORD_W + PITCH_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = PITCH_W;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH    = 1'd1;
    localparam logic [PITCH_W-1:0]   PITCH_RESET      = 13'd256;

    // Pixel formats
    localparam logic FMT_RGB565   = 1'b0;
    localparam logic FMT_XRGB8888 = 1'b1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd2;

    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Input word
    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
        logic [PIXEL_W-1:0] pixel_value;
        logic [ALPHA_W-1:0] alpha;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [PIXEL_W-1:0] read_data;
        logic               out_of_range;
    } out_word_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_wr;
        logic load_item;
        logic calc_product;
        logic calc_base;
        logic pix_write;
        logic rd_issue;
        logic rd_capture;
        logic blend_write;
        logic row_advance;
        logic set_oor;
        logic result_load;
    } abfr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic            clear_done;
        logic [OP_W-1:0] op;
        logic            rect_empty;
        logic            base_oor;
        logic            pix_oor;
        logic            last_col;
        logic            last_row;
    } abfr_status_t;

    // Exact floor(v / 255) for v up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
        return t[15:8];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/abfr_blend.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abfr_blend
// Two-stage per-channel alpha blend of a fill color over a stored pixel.
// Products are registered; divide by 255 and pack follow from those registers.
// ----------------------------------------------------------------------------
module abfr_blend import abfr_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               pixel_format,
    input  wire logic [ALPHA_W-1:0] alpha,
    input  wire logic [PIXEL_W-1:0] fg,
    input  wire logic [PIXEL_W-1:0] bg,
    output logic      [PIXEL_W-1:0] new_pixel
);

    logic [7:0]  fg_r, fg_g, fg_b;
    logic [7:0]  bg_r, bg_g, bg_b;
    logic [7:0]  inv_alpha;
    logic [15:0] mix_r_reg, mix_g_reg, mix_b_reg;
    logic [7:0]  q_r, q_g, q_b;
    logic [PIXEL_W-1:0] blended;
    logic [PIXEL_W-1:0] opaque;

    // Split channels by pixel format
    always_comb begin
        if (pixel_format == FMT_XRGB8888) begin
            fg_r = fg[23:16];
            fg_g = fg[15:8];
            fg_b = fg[7:0];
            bg_r = bg[23:16];
            bg_g = bg[15:8];
            bg_b = bg[7:0];
        end else begin
            fg_r = {3'd0, fg[15:11]};
            fg_g = {2'd0, fg[10:5]};
            fg_b = {3'd0, fg[4:0]};
            bg_r = {3'd0, bg[15:11]};
            bg_g = {2'd0, bg[10:5]};
            bg_b = {3'd0, bg[4:0]};
        end
    end

    assign inv_alpha = ~alpha;

    // Weighted sums per channel
    always_ff @(posedge aclk) begin
        mix_r_reg <= 16'(fg_r) * 16'(alpha) + 16'(bg_r) * 16'(inv_alpha);
        mix_g_reg <= 16'(fg_g) * 16'(alpha) + 16'(bg_g) * 16'(inv_alpha);
        mix_b_reg <= 16'(fg_b) * 16'(alpha) + 16'(bg_b) * 16'(inv_alpha);
    end

    // Divide by 255 and repack
    always_comb begin
        q_r = div255(mix_r_reg);
        q_g = div255(mix_g_reg);
        q_b = div255(mix_b_reg);
        if (pixel_format == FMT_XRGB8888) begin
            blended = {8'd0, q_r, q_g, q_b};
            opaque  = fg;
        end else begin
            blended = {16'd0, q_r[4:0], q_g[5:0], q_b[4:0]};
            opaque  = {16'd0, fg[15:0]};
        end
        new_pixel = (alpha == ALPHA_OPAQUE) ? opaque : blended;
    end

endmodule
`default_nettype wire

// ----- rtl/core/abfr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abfr_ctrl
// Sequencer: clearing pass, operation dispatch, row and pixel walk of a fill,
// and the result word handshake.
// ----------------------------------------------------------------------------
module abfr_ctrl import abfr_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire abfr_status_t status,
    output abfr_cmd_t         cmd
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_MUL      = 4'd2;
    localparam logic [3:0] S_BASE     = 4'd3;
    localparam logic [3:0] S_WR       = 4'd4;
    localparam logic [3:0] S_RD       = 4'd5;
    localparam logic [3:0] S_RD_WAIT  = 4'd6;
    localparam logic [3:0] S_ROW      = 4'd7;
    localparam logic [3:0] S_PIX_RD   = 4'd8;
    localparam logic [3:0] S_PIX_WAIT = 4'd9;
    localparam logic [3:0] S_PIX_MIX  = 4'd10;
    localparam logic [3:0] S_ROW_END  = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (status.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL: begin
                cmd.calc_product = 1'b1;
                state_next       = S_BASE;
            end
            S_BASE: begin
                cmd.calc_base = 1'b1;
                unique case (status.op)
                    OP_WRITE: state_next = S_WR;
                    OP_READ:  state_next = S_RD;
                    OP_FILL:  state_next = status.rect_empty ? S_DONE : S_ROW;
                    default:  state_next = S_DONE;
                endcase
            end
            S_WR: begin
                cmd.set_oor   = status.pix_oor;
                cmd.pix_write = !status.pix_oor;
                state_next    = S_DONE;
            end
            S_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                cmd.set_oor    = status.pix_oor;
                cmd.rd_capture = !status.pix_oor;
                state_next     = S_DONE;
            end
            S_ROW: begin
                if (status.base_oor) begin
                    cmd.set_oor = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    state_next  = S_PIX_RD;
                end
            end
            S_PIX_RD: begin
                if (status.pix_oor) begin
                    cmd.set_oor = 1'b1;
                    state_next  = S_ROW_END;
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_PIX_WAIT;
                end
            end
            S_PIX_WAIT: begin
                state_next = S_PIX_MIX;
            end
            S_PIX_MIX: begin
                cmd.blend_write = 1'b1;
                state_next      = status.last_col ? S_ROW_END : S_PIX_RD;
            end
            S_ROW_END: begin
                cmd.row_advance = 1'b1;
                state_next      = status.last_row ? S_DONE : S_ROW;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result word until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.result_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/abfr_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abfr_datapath
// Frame store, configuration registers, address arithmetic, row and column
// counters, blend unit and result register.
// ----------------------------------------------------------------------------
module abfr_datapath import abfr_pkg::*; #(
    parameter int FB_DEPTH = FB_DEPTH_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire in_word_t              s_data,
    output out_word_t                  m_data,
    input  wire abfr_cmd_t             cmd,
    output abfr_status_t               status
);

    localparam int AW = $clog2(FB_DEPTH);
    localparam logic [AW-1:0]      CLR_LAST   = AW'(FB_DEPTH - 1);
    localparam logic [FULL_AW-1:0] DEPTH_FULL = FULL_AW'(FB_DEPTH);

    logic [PIXEL_W-1:0] frame_mem [FB_DEPTH];

    logic                pixel_format_reg;
    logic [PITCH_W-1:0]  row_pitch_reg;
    in_word_t            item_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [FULL_AW-1:0]  base_reg;
    logic [FULL_AW-1:0]  pix_addr_reg;
    logic [COORD_W-1:0]  col_left_reg;
    logic [COORD_W-1:0]  rows_left_reg;
    logic                oor_reg;
    logic [PIXEL_W-1:0]  rdata_reg;
    logic [PIXEL_W-1:0]  rd_data_reg;
    logic [AW-1:0]       clr_addr_reg;
    out_word_t           result_reg;

    logic [FULL_AW-1:0]  base_next;
    logic [FULL_AW-1:0]  first_base;
    logic [AW-1:0]       pix_idx;
    logic [PIXEL_W-1:0]  blend_pixel;
    logic [PIXEL_W-1:0]  write_pixel;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [PIXEL_W-1:0]  mem_wdata;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg <= FMT_RGB565;
            row_pitch_reg    <= PITCH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PIXEL_FORMAT: pixel_format_reg <= cfg_wdata[0];
                REG_ROW_PITCH:    row_pitch_reg    <= cfg_wdata;
                default:          pixel_format_reg <= pixel_format_reg;
            endcase
        end
    end

    // Clearing pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_wr && (clr_addr_reg != CLR_LAST)) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign first_base  = FULL_AW'(item_reg.x_pos) + FULL_AW'(prod_reg);
    assign base_next   = base_reg + FULL_AW'(row_pitch_reg);
    assign pix_idx     = pix_addr_reg[AW-1:0];
    assign write_pixel = (pixel_format_reg == FMT_XRGB8888) ? item_reg.pixel_value
                                                            : {16'd0, item_reg.pixel_value[15:0]};

    // Capture the word, form addresses, walk rows and columns
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        if (cmd.calc_product) begin
            prod_reg <= PROD_W'(item_reg.y_pos) * PROD_W'(row_pitch_reg);
        end
        if (cmd.calc_base) begin
            base_reg      <= first_base;
            pix_addr_reg  <= first_base;
            col_left_reg  <= item_reg.rect_width;
            rows_left_reg <= item_reg.rect_height;
            oor_reg       <= 1'b0;
            rdata_reg     <= '0;
        end else begin
            if (cmd.blend_write) begin
                pix_addr_reg <= pix_addr_reg + 1'b1;
                col_left_reg <= col_left_reg - 1'b1;
            end
            if (cmd.row_advance) begin
                base_reg      <= base_next;
                pix_addr_reg  <= base_next;
                col_left_reg  <= item_reg.rect_width;
                rows_left_reg <= rows_left_reg - 1'b1;
            end
            if (cmd.set_oor) begin
                oor_reg <= 1'b1;
            end
            if (cmd.rd_capture) begin
                rdata_reg <= (pixel_format_reg == FMT_XRGB8888) ? rd_data_reg
                                                                : {16'd0, rd_data_reg[15:0]};
            end
        end
    end

    abfr_blend u_blend (
        .aclk         (aclk),
        .pixel_format (pixel_format_reg),
        .alpha        (item_reg.alpha),
        .fg           (item_reg.pixel_value),
        .bg           (rd_data_reg),
        .new_pixel    (blend_pixel)
    );

    // Select the single write source
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pix_idx;
        mem_wdata = write_pixel;
        if (cmd.clear_wr) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else if (cmd.pix_write) begin
            mem_we    = 1'b1;
        end else if (cmd.blend_write) begin
            mem_we    = 1'b1;
            mem_wdata = blend_pixel;
        end
    end

    // Frame store: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= frame_mem[pix_idx];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            result_reg.read_data    <= rdata_reg;
            result_reg.out_of_range <= oor_reg;
        end
    end

    assign m_data = result_reg;

    // Status toward the sequencer
    always_comb begin
        status.clear_done = (clr_addr_reg == CLR_LAST);
        status.op         = item_reg.operation;
        status.rect_empty = (item_reg.rect_width == '0) || (item_reg.rect_height == '0);
        status.base_oor   = (base_reg >= DEPTH_FULL);
        status.pix_oor    = (pix_addr_reg >= DEPTH_FULL);
        status.last_col   = (col_left_reg == COORD_W'(1));
        status.last_row   = (rows_left_reg == COORD_W'(1));
    end

endmodule
`default_nettype wire

// ----- rtl/core/alpha_blended_rect_fill.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alpha_blended_rect_fill
// Frame store with pixel write, pixel read and alpha blended rectangle fill.
//
//   channel  direction  handshake           payload
//   s_       in         s_valid / s_ready   in_word_t: op, position, size, color
//   m_       out        m_valid / m_ready   out_word_t: read_data, out_of_range
//   cfg_     in         cfg_wr_en           cfg_index, cfg_wdata
//
// After a word is accepted the sequencer forms the product and base address,
// then writes, reads or walks the fill, and m_valid rises once the result is
// loaded. A fill walks each row that starts inside the store: each pixel takes
// a read, a blend register stage and a write. After reset a clearing pass
// zeroes the store; s_ready stays low until it ends. One word is in work at a
// time; a new word is taken while the last result still waits on m_ready.
// ----------------------------------------------------------------------------
module alpha_blended_rect_fill import abfr_pkg::*; #(
    parameter int FB_DEPTH = FB_DEPTH_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_word_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_word_t                  m_data
);

    abfr_cmd_t    cmd;
    abfr_status_t status;

    abfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    abfr_datapath #(
        .FB_DEPTH (FB_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
`default_nettype wire

// ----- tb/tb_alpha_blended_rect_fill.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alpha_blended_rect_fill
// Self-checking bench for the frame store with pixel write, pixel read and
// alpha blended rectangle fill. A shadow frame store with its own blend math
// predicts each reply word that the directed table does not give, and each
// word from the block is compared field by field in order. A directed table
// covers the edges and the corner cases. Random phases follow under several
// format and pitch settings, bursty sending and a patterned reply stall.
// ----------------------------------------------------------------------------
module tb_alpha_blended_rect_fill import abfr_pkg::*; ();

    localparam int STORE_DEPTH     = FB_DEPTH_DEFAULT;
    localparam int STORE_AW        = $clog2(STORE_DEPTH);
    localparam int WATCHDOG_LIMIT  = 400000;
    localparam int TAIL_CYCLES     = 20;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 95;

    // Operation code the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One row of the directed table: a register setting or a word to send
    typedef struct packed {
        bit                 is_cfg;
        logic               fmt;
        logic [PITCH_W-1:0] pitch;
        in_word_t           word;
        bit                 typed;
        out_word_t          want;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_word_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_word_t             m_data;

    // Shadow of the block: frame store and registers
    bit [31:0]          fb_shadow [STORE_DEPTH];
    logic               pix_fmt     = FMT_RGB565;
    logic [PITCH_W-1:0] row_pitch_q = PITCH_RESET;

    // Reply words owed by the block, oldest first
    out_word_t reply_q [$];
    dir_row_t  dir_tab [$];

    int unsigned fail_count  = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left  = 0;
    int unsigned rx_cycle    = 0;
    int unsigned rx_mode     = 0;
    out_word_t   rx_want;

    // Recent targets, so reads land on pixels that were just drawn
    logic [COORD_W-1:0] last_wr_x = '0, last_wr_y = '0;
    logic [COORD_W-1:0] fill_x = '0, fill_y = '0, fill_w = '0, fill_h = '0;

    int                 row_idx;
    int                 phase;
    int                 item_n;
    dir_row_t           cur_row;
    logic               ph_fmt;
    logic [PITCH_W-1:0] ph_pitch;

    alpha_blended_rect_fill #(
        .FB_DEPTH(STORE_DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #5 aclk = ~aclk;

    // Weighted mix of one channel, truncated
    function automatic bit [7:0] mix_chan(input bit [7:0] f, input bit [7:0] b,
                                          input bit [7:0] a);
        int unsigned acc;
        acc = f * a + b * (255 - a);
        return 8'(acc / 255);
    endfunction

    // New pixel value for a fill over an old one
    function automatic bit [31:0] blended_pixel(input bit [31:0] color,
                                                input bit [31:0] old,
                                                input bit [7:0] a);
        bit [7:0] r, g, bl;
        if (pix_fmt == FMT_RGB565) begin
            if (a == ALPHA_OPAQUE) return {16'h0, color[15:0]};
            r  = mix_chan(8'(color[15:11]), 8'(old[15:11]), a);
            g  = mix_chan(8'(color[10:5]), 8'(old[10:5]), a);
            bl = mix_chan(8'(color[4:0]), 8'(old[4:0]), a);
            return {16'h0, r[4:0], g[5:0], bl[4:0]};
        end
        if (a == ALPHA_OPAQUE) return color;
        r  = mix_chan(color[23:16], old[23:16], a);
        g  = mix_chan(color[15:8], old[15:8], a);
        bl = mix_chan(color[7:0], old[7:0], a);
        return {8'h0, r, g, bl};
    endfunction

    // Apply one word to the shadow store and return the reply it earns
    function automatic out_word_t render_op(input in_word_t w);
        out_word_t       res;
        longint unsigned addr;
        longint unsigned base;
        longint unsigned span;
        longint unsigned row;
        longint unsigned col;
        longint unsigned pix;
        bit              stop;
        res  = '0;
        stop = 1'b0;
        addr = 64'(w.x_pos) + 64'(w.y_pos) * 64'(row_pitch_q);
        case (w.operation)
            OP_WRITE: begin
                if (addr >= STORE_DEPTH) res.out_of_range = 1'b1;
                else fb_shadow[addr[STORE_AW-1:0]] = (pix_fmt == FMT_RGB565) ?
                                       {16'h0, w.pixel_value[15:0]} : w.pixel_value;
            end
            OP_READ: begin
                if (addr >= STORE_DEPTH) res.out_of_range = 1'b1;
                else res.read_data = (pix_fmt == FMT_RGB565) ?
                                     {16'h0, fb_shadow[addr[STORE_AW-1:0]][15:0]} :
                                     fb_shadow[addr[STORE_AW-1:0]];
            end
            OP_FILL: begin
                if (w.rect_width != 0) begin
                    for (row = 0; row < w.rect_height && !stop; row++) begin
                        base = 64'(w.x_pos) + (64'(w.y_pos) + row) * 64'(row_pitch_q);
                        if (base >= STORE_DEPTH) begin
                            // stop at the first row that starts past the store
                            res.out_of_range = 1'b1;
                            stop = 1'b1;
                        end else begin
                            // clip the row at the end of the store
                            span = 64'(w.rect_width);
                            if (span > STORE_DEPTH - base) begin
                                span = STORE_DEPTH - base;
                                res.out_of_range = 1'b1;
                            end
                            for (col = 0; col < span; col++) begin
                                pix = base + col;
                                fb_shadow[pix[STORE_AW-1:0]] =
                                    blended_pixel(w.pixel_value,
                                                  fb_shadow[pix[STORE_AW-1:0]],
                                                  w.alpha);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Random word: mostly in-range pixel ops and small fills, a few big ones
    function automatic in_word_t random_word();
        in_word_t    w;
        int unsigned kind;
        int unsigned sel;
        int unsigned xmax;
        int unsigned ymax;
        w.operation   = OP_WRITE;
        w.x_pos       = COORD_W'($urandom_range(0, 4095));
        w.y_pos       = COORD_W'($urandom_range(0, 4095));
        w.rect_width  = COORD_W'($urandom_range(0, 4095));
        w.rect_height = COORD_W'($urandom_range(0, 4095));
        w.pixel_value = $urandom();
        w.alpha       = ALPHA_W'($urandom_range(0, 255));
        if (row_pitch_q == 0) begin
            xmax = 4095;
            ymax = 4095;
        end else begin
            xmax = (row_pitch_q > 4096) ? 4095 : row_pitch_q - 1;
            ymax = STORE_DEPTH / row_pitch_q - 1;
            if (ymax > 4095) ymax = 4095;
        end
        kind = $urandom_range(0, 99);
        if (kind >= 98) begin
            // noise: all fields random, fills left out for their run time
            sel = $urandom_range(0, 2);
            w.operation = (sel == 0) ? OP_WRITE : (sel == 1) ? OP_READ : OP_UNUSED;
            return w;
        end
        if ($urandom_range(0, 9) != 0) begin
            w.x_pos = COORD_W'($urandom_range(0, xmax));
            w.y_pos = COORD_W'($urandom_range(0, ymax));
        end
        if (kind < 30) begin
            last_wr_x = w.x_pos;
            last_wr_y = w.y_pos;
        end else if (kind < 60) begin
            w.operation = OP_READ;
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
                w.x_pos = last_wr_x;
                w.y_pos = last_wr_y;
            end else if (sel < 7 && fill_w != 0 && fill_h != 0) begin
                w.x_pos = fill_x + COORD_W'($urandom_range(0, fill_w - 1));
                w.y_pos = fill_y + COORD_W'($urandom_range(0, fill_h - 1));
            end
        end else begin
            w.operation = OP_FILL;
            if (kind < 94) begin
                w.rect_width  = COORD_W'($urandom_range(0, 6));
                w.rect_height = COORD_W'($urandom_range(0, 5));
            end else if (kind < 96) begin
                // wide and short
                w.rect_width  = COORD_W'($urandom_range(1, 4095));
                w.rect_height = COORD_W'($urandom_range(1, 2));
            end else begin
                // one column, tall
                w.rect_width  = COORD_W'(1);
                w.rect_height = COORD_W'($urandom_range(1, 4095));
            end
            sel = $urandom_range(0, 9);
            if (sel < 3) w.alpha = ALPHA_OPAQUE;
            else if (sel == 3) w.alpha = '0;
            fill_x = w.x_pos;
            fill_y = w.y_pos;
            fill_w = w.rect_width;
            fill_h = w.rect_height;
        end
        return w;
    endfunction

    // Send one word in bursts with gaps; log its reply on acceptance
    task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
        out_word_t got;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        got = render_op(w);
        reply_q.push_back(typed ? want : got);
    endtask

    // Hold off sending until every owed reply has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (reply_q.size() != 0);
    endtask

    // Write both registers on back-to-back cycles
    task automatic program_regs(input logic fmt, input logic [PITCH_W-1:0] pitch);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PIXEL_FORMAT;
        cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, fmt};
        @(posedge aclk);
        cfg_index <= REG_ROW_PITCH;
        cfg_wdata <= pitch;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        pix_fmt     = fmt;
        row_pitch_q = pitch;
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input int unsigned x,
                           input int unsigned y, input int unsigned wd,
                           input int unsigned ht, input logic [31:0] val,
                           input logic [7:0] a, input int unsigned typed,
                           input logic [31:0] rd, input int unsigned oor);
        dir_row_t r;
        r                  = '0;
        r.word.operation   = op;
        r.word.x_pos       = COORD_W'(x);
        r.word.y_pos       = COORD_W'(y);
        r.word.rect_width  = COORD_W'(wd);
        r.word.rect_height = COORD_W'(ht);
        r.word.pixel_value = val;
        r.word.alpha       = a;
        r.typed            = 1'(typed);
        r.want.read_data   = rd;
        r.want.out_of_range = 1'(oor);
        dir_tab.push_back(r);
    endtask

    task automatic add_cfg(input logic fmt, input logic [PITCH_W-1:0] pitch);
        dir_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.fmt    = fmt;
        r.pitch  = pitch;
        dir_tab.push_back(r);
    endtask

    // Check each reply word against the oldest owed one; stall on a pattern
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (reply_q.size() == 0) begin
                $error("unexpected word: read_data %h out_of_range %b",
                       m_data.read_data, m_data.out_of_range);
                fail_count++;
            end else begin
                rx_want = reply_q.pop_front();
                if (m_data.read_data !== rx_want.read_data) begin
                    $error("read_data: expected %h, actual %h",
                           rx_want.read_data, m_data.read_data);
                    fail_count++;
                end
                if (m_data.out_of_range !== rx_want.out_of_range) begin
                    $error("out_of_range: expected %b, actual %b",
                           rx_want.out_of_range, m_data.out_of_range);
                    fail_count++;
                end
            end
        end
        rx_cycle++;
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (rx_cycle % 5) < 3;
        endcase
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        // Reset settings: RGB565, pitch 256
        add_row(OP_READ,   0,    0,    0,    0,    32'h0,        8'h00, 1, 32'h0,      0);
        add_row(OP_READ,   4095, 4095, 0,    0,    32'h0,        8'h00, 1, 32'h0,      1);
        add_row(OP_WRITE,  0,    0,    4095, 4095, 32'hFFFF_FFFF, 8'hFF, 1, 32'h0,      0);
        add_row(OP_READ,   0,    0,    0,    0,    32'h0,        8'h00, 1, 32'h0000_FFFF, 0);
        add_row(OP_WRITE,  255,  255,  0,    0,    32'h1234_5678, 8'h00, 1, 32'h0,      0);
        add_row(OP_READ,   255,  255,  0,    0,    32'h0,        8'h00, 1, 32'h0000_5678, 0);
        add_row(OP_WRITE,  0,    256,  0,    0,    32'hCAFE_0001, 8'h00, 1, 32'h0,      1);
        add_row(OP_UNUSED, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF, 8'hFF, 1, 32'h0,      0);
        // empty rectangles
        add_row(OP_FILL,   10,   10,   0,    5,    32'hFFFF_FFFF, 8'hFF, 1, 32'h0,      0);
        add_row(OP_FILL,   10,   10,   5,    0,    32'hFFFF_FFFF, 8'hFF, 1, 32'h0,      0);
        // opaque, then alpha zero, then half blend over a shifted rectangle
        add_row(OP_FILL,   16,   16,   4,    3,    32'hA5A5_F81F, 8'hFF, 0, 32'h0,      0);
        add_row(OP_READ,   17,   17,   0,    0,    32'h0,        8'h00, 0, 32'h0,      0);
        add_row(OP_FILL,   16,   16,   4,    3,    32'h0000_FFFF, 8'h00, 0, 32'h0,      0);
        add_row(OP_FILL,   15,   16,   4,    3,    32'h0000_07E0, 8'h80, 0, 32'h0,      0);
        add_row(OP_READ,   18,   17,   0,    0,    32'h0,        8'h00, 0, 32'h0,      0);
        // rectangle running off the end of the store
        add_row(OP_FILL,   250,  255,  10,   2,    32'h0000_001F, 8'h40, 1, 32'h0,      1);
        add_row(OP_READ,   255,  255,  0,    0,    32'h0,        8'h00, 0, 32'h0,      0);
        add_row(OP_FILL,   0,    4095, 3,    3,    32'h0000_1234, 8'hFF, 1, 32'h0,      1);
        add_row(OP_FILL,   0,    100,  4095, 1,    32'h0,        8'hFF, 0, 32'h0,      0);
        add_row(OP_FILL,   4095, 0,    1,    4095, 32'h0000_FFFF, 8'h7F, 0, 32'h0,      0);
        add_row(OP_READ,   4095, 0,    0,    0,    32'h0,        8'h00, 0, 32'h0,      0);
        // 32-bit pixels with pitch zero: every row lands on the same pixels
        add_cfg(FMT_XRGB8888, 13'd0);
        add_row(OP_FILL,   3,    0,    4,    3,    32'h00FF_8040, 8'hC8, 0, 32'h0,      0);
        add_row(OP_READ,   5,    0,    0,    0,    32'h0,        8'h00, 0, 32'h0,      0);
        add_row(OP_FILL,   100,  0,    1,    1,    32'hDEAD_BEEF, 8'hFF, 0, 32'h0,      0);
        add_row(OP_READ,   100,  0,    0,    0,    32'h0,        8'h00, 1, 32'hDEAD_BEEF, 0);
        add_row(OP_READ,   0,    0,    0,    0,    32'h0,        8'h00, 0, 32'h0,      0);
        add_row(OP_WRITE,  4095, 0,    0,    0,    32'hFFFF_FFFF, 8'h00, 0, 32'h0,      0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        for (row_idx = 0; row_idx < dir_tab.size(); row_idx++) begin
            cur_row = dir_tab[row_idx];
            if (cur_row.is_cfg) begin
                drain();
                program_regs(cur_row.fmt, cur_row.pitch);
            end else begin
                send_word(cur_row.word, cur_row.typed, cur_row.want);
            end
        end

        // Random phases over format and pitch settings, extremes included
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       begin ph_fmt = FMT_XRGB8888; ph_pitch = 13'd4096; end
                1:       begin ph_fmt = FMT_RGB565;   ph_pitch = 13'd1;    end
                2:       begin ph_fmt = FMT_XRGB8888; ph_pitch = 13'd0;    end
                3:       begin ph_fmt = FMT_RGB565;   ph_pitch = 13'd8191; end
                4:       begin ph_fmt = FMT_XRGB8888; ph_pitch = 13'd320;  end
                default: begin ph_fmt = FMT_RGB565;   ph_pitch = PITCH_RESET; end
            endcase
            drain();
            program_regs(ph_fmt, ph_pitch);
            for (item_n = 0; item_n < ITEMS_PER_PHASE; item_n++) begin
                if ($urandom_range(0, 59) == 0) drain();
                send_word(random_word(), 1'b0, '0);
            end
        end

        // Let the last replies in, then give stray words a chance to show
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/abfr_pkg.sv
rtl/core/abfr_blend.sv
rtl/core/abfr_ctrl.sv
rtl/core/abfr_datapath.sv
rtl/core/alpha_blended_rect_fill.sv
tb/tb_alpha_blended_rect_fill.sv
